@@ src/dsi_pkg.sv @@
package dsi_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned MagW       = 64;
  localparam int unsigned CountW     = 5;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned MaxDigits  = 20;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  // Work the front hands to the back for one item
  typedef enum logic [1:0] {
    OP_DIGIT,
    OP_NEG,
    OP_ERR,
    OP_TERM
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic [DigitW-1:0] digit;
  } op_t;

  typedef struct packed {
    logic            valid_res;
    logic [MagW-1:0] value;
  } res_t;

endpackage

@@ src/decimal_string_to_int64.sv @@
// Decimal text to signed 64-bit integer converter.
//
// Input channel: one byte of text per item on char_code_i, taken when push_i
// is high and full_o low. A zero byte ends the string; only that item yields
// a result, all other bytes yield none.
// Result channel: while empty_o is low the oldest result sits on valid_res_o
// and value_o; pop it with pop_i. valid_res_o low means the string was empty,
// held a stray character, had too many digits or left the signed 64-bit
// range; value_o is then zero.
// Throughput: one byte per cycle while full_o is low. Each byte costs one step of the back-end
// accumulator (a times-ten-and-add on 64 bits), which sets the rate.
// Path: a terminator passes from the item queue to the accumulator, which writes
// its result into the result queue; from there it reaches the result ports.
// Stalls: a two-entry item queue parts the classifier from the accumulator
// and a two-entry result queue parts the accumulator from the receiver, so a
// held pop_i only stops input once both queues have filled.
// Reset: asynchronous, active low; both queues empty, the parser back at the
// start of a string with a sign allowed.
module decimal_string_to_int64 import dsi_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [CharW-1:0] char_code_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             valid_res_o,
  output logic [MagW-1:0]  value_o
);

  op_t  fr_op, bk_op;
  logic fr_push, q_full, q_empty, bk_pop;
  logic res_full, res_push;
  res_t bk_res, out_res;

  // Front: classify each byte, track whether a sign is still allowed
  dsi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .char_code_i(char_code_i),
    .q_full_i   (q_full),
    .q_push_o   (fr_push),
    .op_o       (fr_op)
  );

  // Hold classified items until the accumulator takes them
  dsi_fifo #(
    .Width($bits(op_t)),
    .Depth(QueueDepth)
  ) u_op_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_push),
    .data_i (fr_op),
    .full_o (q_full),
    .pop_i  (bk_pop),
    .data_o (bk_op),
    .empty_o(q_empty)
  );

  assign full_o = q_full;

  // Back: accumulate digits and form the result on the terminator
  dsi_back #(
    .MaxDig(MAX_DIGITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .op_i      (bk_op),
    .q_pop_o   (bk_pop),
    .res_full_i(res_full),
    .res_push_o(res_push),
    .res_o     (bk_res)
  );

  // Result queue towards the receiver
  dsi_fifo #(
    .Width($bits(res_t)),
    .Depth(QueueDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (bk_res),
    .full_o (res_full),
    .pop_i  (pop_i),
    .data_o (out_res),
    .empty_o(empty_o)
  );

  assign valid_res_o = out_res.valid_res;
  assign value_o     = out_res.value;

endmodule

@@ src/dsi_fifo.sv @@
module dsi_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ src/dsi_front.sv @@
module dsi_front import dsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [CharW-1:0] char_code_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output op_t              op_o
);

  logic start_q, start_d;
  logic accept;
  logic dec_char;
  logic [CharW-1:0] rel;

  assign accept   = push_i && !q_full_i;
  assign dec_char = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  assign rel      = char_code_i - ChZero;

  always_comb begin
    op_o.kind  = OP_ERR;
    op_o.digit = rel[DigitW-1:0];
    q_push_o   = accept;
    start_d    = start_q;
    if (accept) begin
      start_d = (char_code_i == ChNul);
    end
    if (char_code_i == ChNul) begin
      op_o.kind = OP_TERM;
    end else if (start_q && char_code_i == ChMinus) begin
      op_o.kind = OP_NEG;
    end else if (start_q && char_code_i == ChPlus) begin
      // a leading plus changes nothing: drop it here
      q_push_o = 1'b0;
    end else if (dec_char) begin
      op_o.kind = OP_DIGIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
    end else begin
      start_q <= start_d;
    end
  end

endmodule

@@ src/dsi_back.sv @@
module dsi_back import dsi_pkg::*; #(
  parameter int unsigned MaxDig = MaxDigits
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_empty_i,
  input  op_t   op_i,
  output logic  q_pop_o,
  input  logic  res_full_i,
  output logic  res_push_o,
  output res_t  res_o
);

  localparam logic [CountW-1:0] MaxCnt = CountW'(MaxDig);

  logic              neg_q, saw_q, err_q;
  logic [CountW-1:0] cnt_q;
  logic [MagW-1:0]   mag_q;
  logic [MagW+3:0]   next_mag;
  logic              in_range, ok, take;

  // magnitude * 10 + digit, with room to see a wrap
  assign next_mag = {3'b000, mag_q, 1'b0} + {1'b0, mag_q, 3'b000}
                  + {{(MagW){1'b0}}, op_i.digit};

  assign in_range = !mag_q[MagW-1] || (neg_q && mag_q[MagW-2:0] == '0);
  assign ok       = !err_q && (cnt_q != '0 || saw_q) && in_range;

  assign q_pop_o    = !q_empty_i && (op_i.kind != OP_TERM || !res_full_i);
  assign take       = q_pop_o;
  assign res_push_o = take && op_i.kind == OP_TERM;
  assign res_o.valid_res = ok;
  assign res_o.value     = !ok ? '0 : (neg_q ? '0 - mag_q : mag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
      saw_q <= 1'b0;
      err_q <= 1'b0;
      cnt_q <= '0;
      mag_q <= '0;
    end else if (take) begin
      case (op_i.kind)
        OP_TERM: begin
          neg_q <= 1'b0;
          saw_q <= 1'b0;
          err_q <= 1'b0;
          cnt_q <= '0;
          mag_q <= '0;
        end
        OP_NEG: begin
          neg_q <= 1'b1;
        end
        OP_DIGIT: begin
          if (op_i.digit == '0 && cnt_q == '0) begin
            saw_q <= 1'b1;
          end else if (cnt_q >= MaxCnt || next_mag[MagW+3:MagW] != '0) begin
            err_q <= 1'b1;
          end else begin
            mag_q <= next_mag[MagW-1:0];
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: begin
          err_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ src/dsi_checker.sv @@
module dsi_checker import dsi_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push_i,
  input logic [CharW-1:0] char_code_i,
  input logic             full_o,
  input logic             pop_i,
  input logic             empty_o,
  input logic             valid_res_o,
  input logic [MagW-1:0]  value_o
);

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> empty_o && !full_o)
    else $error("queues not empty during reset");

  // A rejected string reports a zero value
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !valid_res_o |-> value_o == '0)
    else $error("invalid result with nonzero value");

  // A result not taken stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(valid_res_o) && $stable(value_o))
    else $error("waiting result changed");

endmodule

bind decimal_string_to_int64 dsi_checker u_dsi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push_i     (push_i),
  .char_code_i(char_code_i),
  .full_o     (full_o),
  .pop_i      (pop_i),
  .empty_o    (empty_o),
  .valid_res_o(valid_res_o),
  .value_o    (value_o)
);

@@ sim/decimal_string_to_int64_test.sv @@
module decimal_string_to_int64_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dsi_pkg::*;

  // Generous ceiling on the whole run, in clock cycles
  localparam int unsigned CycleLimit = 200000;
  // Length of the long receiver hold-off that backs the block up
  localparam int unsigned HoldCycles = 300;
  // Cycles to linger after the last result before the verdict
  localparam int unsigned TailCycles = 8;

  typedef enum bit {
    PARSE_START,
    PARSE_BODY
  } parse_phase_e;

  // Scoreboard: shadow the parser on every accepted byte, queue the result each
  // terminator should produce, and compare popped results against that queue.
  class int64_parse_board;
    parse_phase_e     phase_now;
    bit               negative;
    bit               zero_seen;
    int unsigned      digit_total;
    logic [MagW-1:0]  magnitude;
    bit               faulted;
    res_t             parsed_results[$];
    int unsigned      errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase_now   = PARSE_START;
      negative    = 1'b0;
      zero_seen   = 1'b0;
      digit_total = 0;
      magnitude   = '0;
      faulted     = 1'b0;
    endfunction

    task report_mismatch(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Advance the shadow parser by one accepted byte
    function void take_char(logic [CharW-1:0] code);
      logic [MagW+3:0]   widened;
      logic [MagW-1:0]   bound;
      logic [DigitW-1:0] digit;
      res_t              outcome;
      if (code == ChNul) begin
        // -2^63 is legal, so a negative string may reach one past the signed maximum
        bound = {1'b0, {(MagW-1){1'b1}}} + MagW'(negative);
        if (!faulted && (digit_total != 0 || zero_seen) && magnitude <= bound) begin
          outcome.valid_res = 1'b1;
          outcome.value     = negative ? -magnitude : magnitude;
        end else begin
          outcome = '0;
        end
        parsed_results.push_back(outcome);
        restart();
        return;
      end
      // Only the very first byte of a string may carry a sign
      if (phase_now == PARSE_START) begin
        phase_now = PARSE_BODY;
        if (code == ChMinus) begin
          negative = 1'b1;
          return;
        end
        if (code == ChPlus) return;
      end
      if (code >= ChZero && code <= ChNine) begin
        digit = DigitW'(code - ChZero);
        if (digit == 0 && digit_total == 0) begin
          zero_seen = 1'b1;                       // skip leading zeros
        end else if (digit_total >= MaxDigits) begin
          faulted = 1'b1;                         // one digit too many
        end else begin
          widened = {4'd0, magnitude} * (MagW+4)'(10) + (MagW+4)'(digit);
          if (widened[MagW+3:MagW] != 0) begin
            faulted = 1'b1;                       // would wrap past 2^64-1
          end else begin
            magnitude = widened[MagW-1:0];
            digit_total++;
          end
        end
      end else begin
        faulted = 1'b1;                           // stray byte, keep consuming
      end
    endfunction

    // Compare one popped result with the oldest expectation
    task check_result(logic got_valid, logic [MagW-1:0] got_value);
      res_t wanted;
      if (parsed_results.size() == 0) begin
        report_mismatch($sformatf("result valid_res=%0b value=%0d with nothing pending",
                                  got_valid, $signed(got_value)));
        return;
      end
      wanted = parsed_results.pop_front();
      if (got_valid !== wanted.valid_res)
        report_mismatch($sformatf("valid_res got %0b want %0b", got_valid, wanted.valid_res));
      if (got_value !== wanted.value)
        report_mismatch($sformatf("value got %0d want %0d",
                                  $signed(got_value), $signed(wanted.value)));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             push_i      = 1'b0;
  logic [CharW-1:0] char_code_i = '0;
  logic             full_o;
  logic             pop_i       = 1'b0;
  logic             empty_o;
  logic             valid_res_o;
  logic [MagW-1:0]  value_o;

  int64_parse_board board = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_sent    = 0;
  int unsigned cycle_count   = 0;
  bit          stall_request = 1'b0;

  decimal_string_to_int64 u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .char_code_i (char_code_i),
    .full_o      (full_o),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .valid_res_o (valid_res_o),
    .value_o     (value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: abandon the run if the block never drains
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("decimal_string_to_int64_test: done, errors");
      $finish;
    end
  end

  // Offer one byte, idling at random first, and hold it until the block takes
  // it. push_i is left high afterwards so back-to-back items need no re-raise.
  task automatic send_char(input logic [CharW-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i      <= 1'b1;
    char_code_i <= code;
    do @(posedge clk_i); while (full_o);
    board.take_char(code);
    bytes_sent++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(text[i]);
  endtask

  // Drop push and wait until every pending result has been popped
  task automatic pause_until_drained();
    push_i <= 1'b0;
    do @(posedge clk_i); while (board.parsed_results.size() != 0);
  endtask

  // One random string. Most are well formed with random content; the rest are
  // range-boundary numbers, strings spoiled by one stray byte, or pure noise.
  task automatic send_random_string();
    int unsigned     pick;
    int unsigned     count;
    int unsigned     spoil_at;
    logic [MagW+3:0] near;
    pick = $urandom_range(99);
    if (pick >= 85) begin
      // noise: any nonzero byte, so every bit of the code gets exercised
      count = $urandom_range(8);
      repeat (count) send_char(CharW'($urandom_range(1, 255)));
    end else begin
      case ($urandom_range(2))
        1:       send_char(ChMinus);
        2:       send_char(ChPlus);
        default: ;
      endcase
      if (pick >= 70) begin
        // hover around 2^63-1, 2^63 and the 64-bit wrap point
        case ($urandom_range(2))
          0:       near = 68'h0_7FFF_FFFF_FFFF_FFFF;
          1:       near = 68'h0_8000_0000_0000_0000;
          default: near = 68'h0_FFFF_FFFF_FFFF_FFFF;
        endcase
        near = near + $urandom_range(6);
        near = near - 3;
        send_text($sformatf("%0d", near));
      end else begin
        // occasionally a long run of leading zeros
        count = ($urandom_range(7) == 0) ? $urandom_range(25) : $urandom_range(2);
        repeat (count) send_char(ChZero);
        count    = ($urandom_range(9) == 0) ? $urandom_range(20, 21) : $urandom_range(1, 19);
        spoil_at = (pick >= 55) ? $urandom_range(count - 1) : count;
        for (int i = 0; i < count; i++) begin
          if (i == spoil_at) send_char(CharW'($urandom_range(1, 255)));
          send_char(ChZero + CharW'($urandom_range(9)));
        end
      end
    end
    send_char(ChNul);
  endtask

  // Receiver: pop at random, check each popped result, and on request hold
  // pop low for a long stretch so both internal queues fill and full rises.
  initial begin
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) board.check_result(valid_res_o, value_o);
      if (stall_request) begin
        stall_request = 1'b0;
        pop_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        pop_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    string directed[] = '{
      "", "-", "+", "0", "-0", "+000",
      "9223372036854775807", "9223372036854775808",
      "-9223372036854775808", "-9223372036854775809",
      "18446744073709551615", "18446744073709551616",
      "99999999999999999999", "123456789012345678901",
      "0000000000000000000000001", "-12345678901234567890",
      "+42", "-7", "1-2", "--5", "12a3", "/1", "1:"
    };

    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: sender rarely idles, receiver mostly does
    send_idle_pct = 7;
    recv_idle_pct = 60;
    foreach (directed[i]) begin
      send_text(directed[i]);
      send_char(ChNul);
    end
    // top-bit bytes are stray characters too
    send_char(8'hFF);
    send_char(ChNul);
    send_char(ChMinus);
    send_char(8'h80);
    send_char(ChNul);
    pause_until_drained();

    while (bytes_sent < 350) send_random_string();
    pause_until_drained();

    // Phase two: the other way round
    send_idle_pct = 60;
    recv_idle_pct = 7;
    while (bytes_sent < 700) send_random_string();
    pause_until_drained();

    // Phase three: flat out, opening with a long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b1;
    while (bytes_sent < 1050) send_random_string();

    pause_until_drained();
    repeat (TailCycles) @(posedge clk_i);

    if (board.errors == 0 && board.parsed_results.size() == 0) begin
      $display("decimal_string_to_int64_test: done, clean");
    end else begin
      $display("decimal_string_to_int64_test: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/dsi_pkg.sv
src/dsi_fifo.sv
src/dsi_front.sv
src/dsi_back.sv
src/decimal_string_to_int64.sv
src/dsi_checker.sv
sim/decimal_string_to_int64_test.sv
